>>> hdl/clnsq_pkg.sv
// clnsq_pkg: shared types, constants and the microcode program of the lcd nibble sequencer
`default_nettype none
package clnsq_pkg;

   // channel payloads
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] value;
      logic       row;
      logic [5:0] col;
   } req_type;

   typedef struct packed {
      logic        reg_select;
      logic [3:0]  nibble;
      logic [19:0] wait_before;
      logic [20:0] wait_after;
      logic        last;
   } rsp_type;

   // request modes
   localparam logic [2:0] MODE_INIT       = 3'd0;
   localparam logic [2:0] MODE_COMMAND    = 3'd1;
   localparam logic [2:0] MODE_DATA       = 3'd2;
   localparam logic [2:0] MODE_CLEAR      = 3'd3;
   localparam logic [2:0] MODE_SET_CURSOR = 3'd4;
   localparam logic [2:0] MODE_LINE_START = 3'd5;
   localparam logic [2:0] MODE_LINE_CHAR  = 3'd6;
   localparam logic [2:0] MODE_LINE_END   = 3'd7;

   // csr register indexes
   localparam logic [2:0] CSR_PULSE_WIDTH     = 3'd0;
   localparam logic [2:0] CSR_BYTE_GAP        = 3'd1;
   localparam logic [2:0] CSR_CLEAR_WAIT      = 3'd2;
   localparam logic [2:0] CSR_POWERUP_WAIT    = 3'd3;
   localparam logic [2:0] CSR_INIT_LONG_WAIT  = 3'd4;
   localparam logic [2:0] CSR_INIT_SHORT_WAIT = 3'd5;

   localparam logic [19:0] PULSE_WIDTH_RESET     = 20'd2000;
   localparam logic [19:0] BYTE_GAP_RESET        = 20'd10000;
   localparam logic [19:0] CLEAR_WAIT_RESET      = 20'd80000;
   localparam logic [19:0] POWERUP_WAIT_RESET    = 20'd200000;
   localparam logic [19:0] INIT_LONG_WAIT_RESET  = 20'd80000;
   localparam logic [19:0] INIT_SHORT_WAIT_RESET = 20'd20000;

   localparam int LINE_LENGTH_DEFAULT = 16;
   // one request gives at most 32 nibbles, so a line holds at most 16 characters
   localparam int LINE_CAP = 16;

   localparam logic [7:0] ROW0_BASE = 8'h80;
   localparam logic [7:0] ROW1_BASE = 8'hC0;
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] WAKE_8BIT        = 8'h03;
   localparam logic [7:0] WAKE_4BIT        = 8'h02;
   localparam logic [7:0] CHAR_SPACE       = 8'h20;

   // microcode fields
   typedef enum logic [1:0] {
      BSRC_CONST    = 2'd0,
      BSRC_VALUE    = 2'd1,
      BSRC_CURSOR   = 2'd2,
      BSRC_LINEBASE = 2'd3
   } bsrc_type;

   typedef enum logic [2:0] {
      AFT_PW           = 3'd0,
      AFT_PW_LONG      = 3'd1,
      AFT_PW_SHORT     = 3'd2,
      AFT_PW_GAP       = 3'd3,
      AFT_PW_GAP_CLEAR = 3'd4
   } after_type;

   typedef enum logic [1:0] {
      COL_NONE  = 2'd0,
      COL_CLEAR = 2'd1,
      COL_INC   = 2'd2
   } colop_type;

   typedef enum logic [1:0] {
      SEQ_NEXT        = 2'd0,
      SEQ_END         = 2'd1,
      SEQ_END_IF_FULL = 2'd2,
      SEQ_LOOP_OR_END = 2'd3
   } seq_type;

   typedef logic [4:0] uaddr_type;

   typedef struct packed {
      logic       emit;
      bsrc_type   bsrc;
      logic [7:0] konst;
      logic       lo_half;
      logic       rs;
      logic       powerup;
      after_type  after;
      colop_type  colop;
      seq_type    seq;
      uaddr_type  target;
   } uword_type;

   // line condition flags from the datapath
   typedef struct packed {
      logic full;
      logic full_next;
   } cond_type;

   // sequencer status toward the datapath
   typedef struct packed {
      uword_type uw;
      logic      step;
      logic      last;
      logic      busy;
   } seq_out_type;

   // program entry points
   localparam uaddr_type UA_INIT       = 5'd0;
   localparam uaddr_type UA_COMMAND    = 5'd14;
   localparam uaddr_type UA_DATA       = 5'd16;
   localparam uaddr_type UA_CLEAR      = 5'd18;
   localparam uaddr_type UA_SET_CURSOR = 5'd20;
   localparam uaddr_type UA_LINE_START = 5'd22;
   localparam uaddr_type UA_LINE_CHAR  = 5'd24;
   localparam uaddr_type UA_LINE_END   = 5'd27;

   function automatic uword_type mk(input logic emit, input bsrc_type bsrc,
                                    input logic [7:0] konst, input logic lo_half,
                                    input logic rs, input logic powerup,
                                    input after_type after, input colop_type colop,
                                    input seq_type seq, input uaddr_type target);
      uword_type w;
      w.emit    = emit;
      w.bsrc    = bsrc;
      w.konst   = konst;
      w.lo_half = lo_half;
      w.rs      = rs;
      w.powerup = powerup;
      w.after   = after;
      w.colop   = colop;
      w.seq     = seq;
      w.target  = target;
      return w;
   endfunction

   function automatic uaddr_type entry_addr(input logic [2:0] mode);
      uaddr_type a;
      unique case (mode)
         MODE_INIT:       a = UA_INIT;
         MODE_COMMAND:    a = UA_COMMAND;
         MODE_DATA:       a = UA_DATA;
         MODE_CLEAR:      a = UA_CLEAR;
         MODE_SET_CURSOR: a = UA_SET_CURSOR;
         MODE_LINE_START: a = UA_LINE_START;
         MODE_LINE_CHAR:  a = UA_LINE_CHAR;
         default:         a = UA_LINE_END;
      endcase
      return a;
   endfunction

   // control store: one word per step
   function automatic uword_type ucode_rom(input uaddr_type addr);
      uword_type w;
      unique case (addr)
         // power-up nibbles 3,3,3,2 come from the low half of a constant
         5'd0:  w = mk(1'b1, BSRC_CONST, WAKE_8BIT, 1'b1, 1'b0, 1'b1, AFT_PW_LONG,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd1:  w = mk(1'b1, BSRC_CONST, WAKE_8BIT, 1'b1, 1'b0, 1'b0, AFT_PW_SHORT,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd2:  w = mk(1'b1, BSRC_CONST, WAKE_8BIT, 1'b1, 1'b0, 1'b0, AFT_PW_SHORT,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd3:  w = mk(1'b1, BSRC_CONST, WAKE_4BIT, 1'b1, 1'b0, 1'b0, AFT_PW_SHORT,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd4:  w = mk(1'b1, BSRC_CONST, CMD_FUNCTION_SET, 1'b0, 1'b0, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd5:  w = mk(1'b1, BSRC_CONST, CMD_FUNCTION_SET, 1'b1, 1'b0, 1'b0, AFT_PW_GAP,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd6:  w = mk(1'b1, BSRC_CONST, CMD_DISPLAY_OFF, 1'b0, 1'b0, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd7:  w = mk(1'b1, BSRC_CONST, CMD_DISPLAY_OFF, 1'b1, 1'b0, 1'b0, AFT_PW_GAP,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd8:  w = mk(1'b1, BSRC_CONST, CMD_CLEAR, 1'b0, 1'b0, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd9:  w = mk(1'b1, BSRC_CONST, CMD_CLEAR, 1'b1, 1'b0, 1'b0, AFT_PW_GAP_CLEAR,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd10: w = mk(1'b1, BSRC_CONST, CMD_ENTRY_MODE, 1'b0, 1'b0, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd11: w = mk(1'b1, BSRC_CONST, CMD_ENTRY_MODE, 1'b1, 1'b0, 1'b0, AFT_PW_GAP,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd12: w = mk(1'b1, BSRC_CONST, CMD_DISPLAY_ON, 1'b0, 1'b0, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd13: w = mk(1'b1, BSRC_CONST, CMD_DISPLAY_ON, 1'b1, 1'b0, 1'b0, AFT_PW_GAP,
                       COL_NONE, SEQ_END, UA_INIT);
         // command
         5'd14: w = mk(1'b1, BSRC_VALUE, CHAR_SPACE, 1'b0, 1'b0, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd15: w = mk(1'b1, BSRC_VALUE, CHAR_SPACE, 1'b1, 1'b0, 1'b0, AFT_PW_GAP,
                       COL_NONE, SEQ_END, UA_INIT);
         // data
         5'd16: w = mk(1'b1, BSRC_VALUE, CHAR_SPACE, 1'b0, 1'b1, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd17: w = mk(1'b1, BSRC_VALUE, CHAR_SPACE, 1'b1, 1'b1, 1'b0, AFT_PW_GAP,
                       COL_NONE, SEQ_END, UA_INIT);
         // clear
         5'd18: w = mk(1'b1, BSRC_CONST, CMD_CLEAR, 1'b0, 1'b0, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd19: w = mk(1'b1, BSRC_CONST, CMD_CLEAR, 1'b1, 1'b0, 1'b0, AFT_PW_GAP_CLEAR,
                       COL_NONE, SEQ_END, UA_INIT);
         // set cursor
         5'd20: w = mk(1'b1, BSRC_CURSOR, CHAR_SPACE, 1'b0, 1'b0, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd21: w = mk(1'b1, BSRC_CURSOR, CHAR_SPACE, 1'b1, 1'b0, 1'b0, AFT_PW_GAP,
                       COL_NONE, SEQ_END, UA_INIT);
         // line start opens the line
         5'd22: w = mk(1'b1, BSRC_LINEBASE, CHAR_SPACE, 1'b0, 1'b0, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd23: w = mk(1'b1, BSRC_LINEBASE, CHAR_SPACE, 1'b1, 1'b0, 1'b0, AFT_PW_GAP,
                       COL_CLEAR, SEQ_END, UA_INIT);
         // line char, dropped on a closed or full line
         5'd24: w = mk(1'b0, BSRC_VALUE, CHAR_SPACE, 1'b0, 1'b1, 1'b0, AFT_PW,
                       COL_NONE, SEQ_END_IF_FULL, UA_INIT);
         5'd25: w = mk(1'b1, BSRC_VALUE, CHAR_SPACE, 1'b0, 1'b1, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd26: w = mk(1'b1, BSRC_VALUE, CHAR_SPACE, 1'b1, 1'b1, 1'b0, AFT_PW_GAP,
                       COL_INC, SEQ_END, UA_INIT);
         // line end pads spaces until the line is full
         5'd27: w = mk(1'b0, BSRC_CONST, CHAR_SPACE, 1'b0, 1'b1, 1'b0, AFT_PW,
                       COL_NONE, SEQ_END_IF_FULL, UA_INIT);
         5'd28: w = mk(1'b1, BSRC_CONST, CHAR_SPACE, 1'b0, 1'b1, 1'b0, AFT_PW,
                       COL_NONE, SEQ_NEXT, UA_INIT);
         5'd29: w = mk(1'b1, BSRC_CONST, CHAR_SPACE, 1'b1, 1'b1, 1'b0, AFT_PW_GAP,
                       COL_INC, SEQ_LOOP_OR_END, UA_LINE_END);
         default: w = mk(1'b0, BSRC_CONST, CHAR_SPACE, 1'b0, 1'b0, 1'b0, AFT_PW,
                         COL_NONE, SEQ_END, UA_INIT);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> hdl/clnsq_useq.sv
// clnsq_useq: step counter, control store fetch and jump logic
`default_nettype none
module clnsq_useq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [2:0]             mode,
   input  wire clnsq_pkg::cond_type    cond,
   input  wire logic                   out_room,
   output clnsq_pkg::seq_out_type      status
);

   clnsq_pkg::uaddr_type pc_ff, pc_in;
   logic                 busy_ff, busy_in;
   clnsq_pkg::uword_type uw;
   logic                 step;

   always_comb begin
      uw      = clnsq_pkg::ucode_rom(pc_ff);
      // an emitting step waits for room in the output register
      step    = busy_ff && (!uw.emit || out_room);
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = clnsq_pkg::entry_addr(mode);
      end else if (step) begin
         unique case (uw.seq)
            clnsq_pkg::SEQ_NEXT: begin
               pc_in = pc_ff + 5'd1;
            end
            clnsq_pkg::SEQ_END: begin
               busy_in = 1'b0;
            end
            clnsq_pkg::SEQ_END_IF_FULL: begin
               if (cond.full) begin
                  busy_in = 1'b0;
               end else begin
                  pc_in = pc_ff + 5'd1;
               end
            end
            clnsq_pkg::SEQ_LOOP_OR_END: begin
               if (cond.full_next) begin
                  busy_in = 1'b0;
               end else begin
                  pc_in = uw.target;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= clnsq_pkg::UA_INIT;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   always_comb begin
      status.uw   = uw;
      status.step = step;
      status.busy = busy_ff;
      status.last = (uw.seq == clnsq_pkg::SEQ_END) ||
                    ((uw.seq == clnsq_pkg::SEQ_LOOP_OR_END) && cond.full_next);
   end

endmodule
`default_nettype wire

>>> hdl/char_lcd_nibble_sequencer_core.sv
// char_lcd_nibble_sequencer_core: lcd request to 4-bit nibble strobe sequencer, top level
//
//   channel   direction  handshake          beat
//   req_      in         valid / stall      req_type: mode, value, row, col
//   rsp_      out        valid / stall      rsp_type: reg_select, nibble, waits, last
//   csr_      in         write enable only  index 0..5, 20-bit data
//
// one request at a time: the request is accepted, then one microcode step runs per cycle
// (2 steps for a byte, 14 for init, 3 for a line char, 3 per padded space, 1 for a dropped
// char or a line end with nothing to pad) while the output register takes every beat.
// a stalled rsp_ holds the step counter on its next emitting step.
// reset is synchronous; csr registers return to their defaults and the line closes.

`default_nettype none
module char_lcd_nibble_sequencer_core #(
   parameter int LINE_LENGTH = clnsq_pkg::LINE_LENGTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire clnsq_pkg::req_type  req_payload,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      clnsq_pkg::rsp_type  rsp_payload,
   input  wire logic                csr_we,
   input  wire logic [2:0]          csr_index,
   input  wire logic [19:0]         csr_wdata
);

   localparam logic [4:0] LineEff = 5'((LINE_LENGTH > clnsq_pkg::LINE_CAP) ?
                                       clnsq_pkg::LINE_CAP : LINE_LENGTH);

   logic [19:0] pulse_width_ff, byte_gap_ff, clear_wait_ff;
   logic [19:0] powerup_wait_ff, init_long_wait_ff, init_short_wait_ff;

   clnsq_pkg::req_type req_ff, req_in;
   logic [4:0]         col_ff, col_in;
   logic               rsp_valid_ff, rsp_valid_in;
   clnsq_pkg::rsp_type rsp_ff, rsp_in;

   logic                   start;
   logic                   out_room;
   clnsq_pkg::cond_type    cond;
   clnsq_pkg::seq_out_type status;
   clnsq_pkg::uword_type   uw;
   logic [7:0]             row_base;
   logic [7:0]             byte_sel;
   logic [19:0]            add_a, add_b;
   logic [21:0]            after_sum;
   logic [5:0]             col_next;

   assign req_stall = status.busy;
   assign start     = req_valid && !status.busy;
   assign out_room  = !rsp_valid_ff || !rsp_stall;
   assign col_next  = {1'b0, col_ff} + 6'd1;
   assign cond.full      = (col_ff >= LineEff);
   assign cond.full_next = (col_next >= {1'b0, LineEff});
   assign uw = status.uw;

   clnsq_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .mode     (req_payload.mode),
      .cond     (cond),
      .out_room (out_room),
      .status   (status)
   );

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff     <= clnsq_pkg::PULSE_WIDTH_RESET;
         byte_gap_ff        <= clnsq_pkg::BYTE_GAP_RESET;
         clear_wait_ff      <= clnsq_pkg::CLEAR_WAIT_RESET;
         powerup_wait_ff    <= clnsq_pkg::POWERUP_WAIT_RESET;
         init_long_wait_ff  <= clnsq_pkg::INIT_LONG_WAIT_RESET;
         init_short_wait_ff <= clnsq_pkg::INIT_SHORT_WAIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            clnsq_pkg::CSR_PULSE_WIDTH:     pulse_width_ff     <= csr_wdata;
            clnsq_pkg::CSR_BYTE_GAP:        byte_gap_ff        <= csr_wdata;
            clnsq_pkg::CSR_CLEAR_WAIT:      clear_wait_ff      <= csr_wdata;
            clnsq_pkg::CSR_POWERUP_WAIT:    powerup_wait_ff    <= csr_wdata;
            clnsq_pkg::CSR_INIT_LONG_WAIT:  init_long_wait_ff  <= csr_wdata;
            clnsq_pkg::CSR_INIT_SHORT_WAIT: init_short_wait_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // datapath driven by the current control word
   always_comb begin
      row_base = req_ff.row ? clnsq_pkg::ROW1_BASE : clnsq_pkg::ROW0_BASE;
      unique case (uw.bsrc)
         clnsq_pkg::BSRC_CONST:    byte_sel = uw.konst;
         clnsq_pkg::BSRC_VALUE:    byte_sel = req_ff.value;
         clnsq_pkg::BSRC_CURSOR:   byte_sel = row_base + {2'b00, req_ff.col};
         clnsq_pkg::BSRC_LINEBASE: byte_sel = row_base;
         default:                  byte_sel = uw.konst;
      endcase

      unique case (uw.after)
         clnsq_pkg::AFT_PW: begin
            add_a = '0;
            add_b = '0;
         end
         clnsq_pkg::AFT_PW_LONG: begin
            add_a = init_long_wait_ff;
            add_b = '0;
         end
         clnsq_pkg::AFT_PW_SHORT: begin
            add_a = init_short_wait_ff;
            add_b = '0;
         end
         clnsq_pkg::AFT_PW_GAP: begin
            add_a = byte_gap_ff;
            add_b = '0;
         end
         clnsq_pkg::AFT_PW_GAP_CLEAR: begin
            add_a = byte_gap_ff;
            add_b = clear_wait_ff;
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
      after_sum = {2'b00, pulse_width_ff} + {2'b00, add_a} + {2'b00, add_b};
   end

   always_comb begin
      req_in       = start ? req_payload : req_ff;
      col_in       = col_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (status.step) begin
         unique case (uw.colop)
            clnsq_pkg::COL_NONE:  col_in = col_ff;
            clnsq_pkg::COL_CLEAR: col_in = '0;
            clnsq_pkg::COL_INC:   col_in = col_next[4:0];
            default:              col_in = col_ff;
         endcase
         if (uw.emit) begin
            rsp_valid_in       = 1'b1;
            rsp_in.reg_select  = uw.rs;
            rsp_in.nibble      = uw.lo_half ? byte_sel[3:0] : byte_sel[7:4];
            rsp_in.wait_before = uw.powerup ? powerup_wait_ff : '0;
            // saturate to the 21-bit field
            rsp_in.wait_after  = after_sum[21] ? '1 : after_sum[20:0];
            rsp_in.last        = status.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= LineEff;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
